/* hdl/dmc_pkg.sv */
// Package for the direct-mapped write-back cache.
// Opcode codes, counter indexes and the output record type. No dependencies.
package dmc_pkg;
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int CNT_NUM = 5;
  localparam logic [2:0] C_RHIT  = 3'd0;
  localparam logic [2:0] C_RMISS = 3'd1;
  localparam logic [2:0] C_WHIT  = 3'd2;
  localparam logic [2:0] C_WMISS = 3'd3;
  localparam logic [2:0] C_WBACK = 3'd4;

  typedef struct packed {
    logic [31:0] writeback_count;
    logic [31:0] write_miss_count;
    logic [31:0] write_hit_count;
    logic [31:0] read_miss_count;
    logic [31:0] read_hit_count;
    logic        hit;
    logic [31:0] read_data;
  } result_t;
endpackage

/* hdl/direct_mapped_writeback_cache.sv */
// Direct-mapped write-back write-allocate cache over a backing word memory; uses dmc_pkg.
// One request at a time: a read or write looks up the tag; a miss first writes back
// a dirty victim line, then fills the line from backing memory; then the word is accessed.
// Flush writes back each valid dirty set and invalidates every set. Synchronous RAMs.
// After rst an init pass loads each backing word with its own address;
// no request is taken during it. Valid/dirty/counters reset at once.
module direct_mapped_writeback_cache #(
  parameter int SET_COUNT  = 16,
  parameter int LINE_WORDS = 32,
  parameter int ADDR_BITS  = 16,
  parameter int DATA_BITS  = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [55:0]  s_tdata,   // opcode[1:0], address[17:2], write_data[49:18], zero
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [199:0] m_tdata    // read_data, hit, read_hit, read_miss, write_hit,
                                  // write_miss, writeback counts; zero fill
);
  localparam int OB = $clog2(LINE_WORDS);
  localparam int SB = $clog2(SET_COUNT);
  localparam int TB = ADDR_BITS - OB - SB;
  localparam int TW = (TB > 0) ? TB : 1;
  localparam int LB = SB + OB;
  localparam int MEMW = 1 << ADDR_BITS;

  localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_LOOK = 4'd2, S_WB = 4'd3,
                         S_FILL = 4'd4, S_ACC = 4'd5, S_ACC2 = 4'd6, S_FLK = 4'd7,
                         S_FLT = 4'd8, S_OUT = 4'd9;

  logic [DATA_BITS-1:0] bmem [MEMW];
  logic [DATA_BITS-1:0] lmem [SET_COUNT*LINE_WORDS];
  logic [TW-1:0]        tmem [SET_COUNT];
  logic [SET_COUNT-1:0] valid, dirty;

  logic [3:0] state;
  logic [1:0] op;
  logic [ADDR_BITS-1:0] addr;
  logic [DATA_BITS-1:0] wdata;
  logic [31:0] cnt [dmc_pkg::CNT_NUM];
  logic [ADDR_BITS:0] icnt;
  logic [OB:0] k;
  logic rd_ph;
  logic [SB:0] fs;
  logic [TW-1:0] tag_q;
  logic [DATA_BITS-1:0] lrd, brd;
  logic is_hit;
  dmc_pkg::result_t res;

  logic [OB-1:0] off;
  logic [SB-1:0] set;
  logic [TW-1:0] tag;
  assign off = addr[OB-1:0];
  assign set = addr[LB-1:OB];
  if (TB > 0) begin : g_tag
    assign tag = addr[ADDR_BITS-1:LB];
  end else begin : g_notag
    assign tag = '0;
  end

  logic [SB-1:0] cur_set;
  assign cur_set = (state == S_FLK || state == S_FLT) ? fs[SB-1:0] :
                   (state == S_IDLE) ? s_tdata[OB+2 +: SB] : set;

  function automatic logic [ADDR_BITS-1:0] base_of(input logic [TW-1:0] t,
                                                   input logic [SB-1:0] s);
    logic [ADDR_BITS+TW+SB:0] v;
    v = (ADDR_BITS+TW+SB+1)'({t, s}) << OB;
    return v[ADDR_BITS-1:0];
  endfunction

  // line memory port
  logic [LB-1:0] l_ra;
  logic l_we;
  logic [LB-1:0] l_wa;
  logic [DATA_BITS-1:0] l_wd;
  // backing memory port
  logic b_we;
  logic [ADDR_BITS-1:0] b_a;
  logic [DATA_BITS-1:0] b_wd;

  always_comb begin
    l_ra = {cur_set, k[OB-1:0]};
    l_we = 1'b0; l_wa = {set, off}; l_wd = wdata;
    b_we = 1'b0; b_a = base_of(tag, set) + ADDR_BITS'(k[OB-1:0]);
    b_wd = lrd;
    case (state)
      S_INIT: begin
        b_we = 1'b1; b_a = icnt[ADDR_BITS-1:0]; b_wd = DATA_BITS'(icnt[ADDR_BITS-1:0]);
      end
      S_WB, S_FLT: begin
        b_we = rd_ph && (k != '0);
        b_a = base_of(tag_q, cur_set) + ADDR_BITS'(OB'(k[OB-1:0] - 1'b1));
      end
      S_FILL: begin
        l_we = rd_ph && (k != '0); l_wa = {set, OB'(k[OB-1:0] - 1'b1)}; l_wd = brd;
      end
      S_ACC: begin
        l_ra = {set, off};
        l_we = (op == dmc_pkg::OP_WRITE);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    lrd <= lmem[l_ra];
    if (l_we) lmem[l_wa] <= l_wd;
    if (b_we) bmem[b_a] <= b_wd;
    brd <= bmem[b_a];
    tag_q <= tmem[cur_set];
    if (state == S_FILL && k == '0 && !rd_ph) tmem[set] <= tag;
  end

  function automatic logic [31:0] sat(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign m_tdata = {7'd0, res};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; icnt <= '0; valid <= '0; dirty <= '0; m_tvalid <= 1'b0;
      for (int i = 0; i < dmc_pkg::CNT_NUM; i++) cnt[i] <= '0;
      k <= '0; rd_ph <= 1'b0; fs <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_INIT: begin
          icnt <= icnt + 1'b1;
          if (icnt == (ADDR_BITS+1)'(MEMW - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_tvalid && s_tready) begin
          op <= s_tdata[1:0]; addr <= ADDR_BITS'(s_tdata[17:2]);
          wdata <= DATA_BITS'(s_tdata[49:18]);
          res <= '0; k <= '0; rd_ph <= 1'b0; fs <= '0;
          case (s_tdata[1:0])
            dmc_pkg::OP_READ, dmc_pkg::OP_WRITE: state <= S_LOOK;
            dmc_pkg::OP_FLUSH: state <= S_FLK;
            default: state <= S_OUT;
          endcase
        end
        S_LOOK: begin
          is_hit <= valid[set] && tag_q == tag;
          if (valid[set] && tag_q == tag) state <= S_ACC;
          else if (dirty[set]) state <= S_WB;
          else state <= S_FILL;
        end
        S_WB, S_FLT: begin
          // overlapped: issue read of word k while writing word k-1, read the cycle before
          if (k == (OB+1)'(LINE_WORDS)) begin
            k <= '0; rd_ph <= 1'b0;
            dirty[cur_set] <= 1'b0;
            cnt[dmc_pkg::C_WBACK] <= sat(cnt[dmc_pkg::C_WBACK]);
            if (state == S_WB) state <= S_FILL;
            else begin
              valid[cur_set] <= 1'b0;
              fs <= fs + 1'b1;
              state <= (fs == (SB+1)'(SET_COUNT - 1)) ? S_OUT : S_FLK;
            end
          end else begin
            rd_ph <= 1'b1;
            k <= k + 1'b1;
          end
        end
        S_FILL: begin
          if (k == (OB+1)'(LINE_WORDS)) begin
            k <= '0; rd_ph <= 1'b0;
            valid[set] <= 1'b1; dirty[set] <= 1'b0;
            state <= S_ACC;
          end else begin
            rd_ph <= 1'b1;
            k <= k + 1'b1;
          end
        end
        S_ACC: begin
          res.hit <= is_hit;
          if (op == dmc_pkg::OP_WRITE) begin
            dirty[set] <= 1'b1;
            if (is_hit) cnt[dmc_pkg::C_WHIT] <= sat(cnt[dmc_pkg::C_WHIT]);
            else cnt[dmc_pkg::C_WMISS] <= sat(cnt[dmc_pkg::C_WMISS]);
            state <= S_OUT;
          end else begin
            if (is_hit) cnt[dmc_pkg::C_RHIT] <= sat(cnt[dmc_pkg::C_RHIT]);
            else cnt[dmc_pkg::C_RMISS] <= sat(cnt[dmc_pkg::C_RMISS]);
            state <= S_ACC2;
          end
        end
        S_ACC2: begin
          res.read_data <= 32'(lrd);
          state <= S_OUT;
        end
        S_FLK: begin
          // tag of set fs is read this cycle
          if (valid[fs[SB-1:0]] && dirty[fs[SB-1:0]]) state <= S_FLT;
          else begin
            valid[fs[SB-1:0]] <= 1'b0; dirty[fs[SB-1:0]] <= 1'b0;
            fs <= fs + 1'b1;
            if (fs == (SB+1)'(SET_COUNT - 1)) state <= S_OUT;
          end
        end
        S_OUT: begin
          if (op == dmc_pkg::OP_FLUSH) begin
            res.read_hit_count <= cnt[dmc_pkg::C_RHIT];
            res.read_miss_count <= cnt[dmc_pkg::C_RMISS];
            res.write_hit_count <= cnt[dmc_pkg::C_WHIT];
            res.write_miss_count <= cnt[dmc_pkg::C_WMISS];
            res.writeback_count <= cnt[dmc_pkg::C_WBACK];
            for (int i = 0; i < dmc_pkg::CNT_NUM; i++) cnt[i] <= '0;
          end
          m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* hdl/dmc_checker.sv */
// Port checker for direct_mapped_writeback_cache, bound to the top level.
// Depends on the top level's ports only.
module dmc_port_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [199:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("second request taken");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("request taken with result pending");
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("valid out of reset");
endmodule

bind direct_mapped_writeback_cache dmc_port_checker u_dmc_checker (.*);

/* tb/dmc_checker.sv */
// Checker for the direct-mapped write-back cache: watches both stream channels,
// keeps its own copy of backing memory, lines and counters, compares each result.
// Depends on dmc_pkg.
module dmc_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [55:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [199:0] m_tdata,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS = 16;
  localparam int WPL = 32;

  logic [31:0]      mem_words [65536];
  logic [31:0]      cache_words [SETS*WPL];
  logic [6:0]       tags [SETS];
  logic             valid [SETS];
  logic             dirty [SETS];
  logic [31:0]      counters [dmc_pkg::CNT_NUM];
  dmc_pkg::result_t expected_q [$];

  function automatic void bump(logic [2:0] which);
    if (counters[which] != 32'hFFFF_FFFF) counters[which]++;
  endfunction

  function automatic void evict(int set);
    logic [15:0] base;
    base = {tags[set], set[3:0], 5'd0};
    for (int k = 0; k < WPL; k++) mem_words[base + k] = cache_words[set*WPL + k];
    dirty[set] = 1'b0;
    bump(dmc_pkg::C_WBACK);
  endfunction

  function automatic dmc_pkg::result_t predict_access(logic [1:0] op, logic [15:0] addr,
                                                      logic [31:0] wdata);
    dmc_pkg::result_t r;
    int set, idx;
    logic [6:0] tag;
    logic [15:0] base;
    logic hit;
    r = '0;
    set = addr[8:5];
    tag = addr[15:9];
    idx = set*WPL + addr[4:0];
    if (op == dmc_pkg::OP_READ || op == dmc_pkg::OP_WRITE) begin
      hit = valid[set] && tags[set] == tag;
      if (!hit) begin
        if (dirty[set]) evict(set);
        base = {tag, addr[8:5], 5'd0};
        for (int k = 0; k < WPL; k++) cache_words[set*WPL + k] = mem_words[base + k];
        tags[set] = tag;
        valid[set] = 1'b1;
        dirty[set] = 1'b0;
      end
      if (op == dmc_pkg::OP_WRITE) begin
        cache_words[idx] = wdata;
        dirty[set] = 1'b1;
        bump(hit ? dmc_pkg::C_WHIT : dmc_pkg::C_WMISS);
      end else begin
        r.read_data = cache_words[idx];
        bump(hit ? dmc_pkg::C_RHIT : dmc_pkg::C_RMISS);
      end
      r.hit = hit;
    end else if (op == dmc_pkg::OP_FLUSH) begin
      for (int s = 0; s < SETS; s++) begin
        if (valid[s] && dirty[s]) evict(s);
        valid[s] = 1'b0;
        dirty[s] = 1'b0;
      end
      r.read_hit_count   = counters[dmc_pkg::C_RHIT];
      r.read_miss_count  = counters[dmc_pkg::C_RMISS];
      r.write_hit_count  = counters[dmc_pkg::C_WHIT];
      r.write_miss_count = counters[dmc_pkg::C_WMISS];
      r.writeback_count  = counters[dmc_pkg::C_WBACK];
      for (int j = 0; j < dmc_pkg::CNT_NUM; j++) counters[j] = '0;
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    dmc_pkg::result_t got, want;
    if (rst) begin
      for (int i = 0; i < 65536; i++) mem_words[i] = 32'(i);
      for (int s = 0; s < SETS; s++) begin
        tags[s] = '0;
        valid[s] = 1'b0;
        dirty[s] = 1'b0;
      end
      for (int j = 0; j < dmc_pkg::CNT_NUM; j++) counters[j] = '0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_q.push_back(predict_access(s_tdata[1:0], s_tdata[17:2], s_tdata[49:18]));
      if (m_tvalid && m_tready) begin
        got = m_tdata[192:0];
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: exp data %h hit %b cnt %h %h %h %h %h", want.read_data,
                       want.hit, want.read_hit_count, want.read_miss_count,
                       want.write_hit_count, want.write_miss_count, want.writeback_count);
              $display("          got data %h hit %b cnt %h %h %h %h %h", got.read_data,
                       got.hit, got.read_hit_count, got.read_miss_count,
                       got.write_hit_count, got.write_miss_count, got.writeback_count);
            end
          end
        end
      end
    end
  end
endmodule

/* tb/tb.sv */
// Testbench top, depends on direct_mapped_writeback_cache, dmc_pkg, dmc_checker:
// reset, directed and random requests, random backpressure, verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [55:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [199:0] m_tdata;
  int           errors;
  int           pending;
  int           idle_cycles = 0;
  logic [15:0]  hot_addr [8];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  direct_mapped_writeback_cache DUT (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  dmc_checker checker_i (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_request(logic [1:0] op, logic [15:0] addr, logic [31:0] wdata);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {6'd0, wdata, addr, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 99) < 8) m_tready <= 1'b0;
      else if ($urandom_range(0, 99) < 70) m_tready <= 1'b1;
    end
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT + 65536) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [1:0] pick_op();
    int p;
    p = $urandom_range(0, 99);
    if (p < 47) return dmc_pkg::OP_READ;
    if (p < 94) return dmc_pkg::OP_WRITE;
    if (p < 98) return dmc_pkg::OP_FLUSH;
    return dmc_pkg::OP_UNUSED;
  endfunction

  initial begin
    logic [15:0] a;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // extremes, conflicts on one set, every opcode
    send_request(dmc_pkg::OP_READ, 16'h0000, 32'h0);
    send_request(dmc_pkg::OP_READ, 16'h0000, 32'hFFFF_FFFF);
    send_request(dmc_pkg::OP_WRITE, 16'h0000, 32'hFFFF_FFFF);
    send_request(dmc_pkg::OP_WRITE, 16'hFFFF, 32'h0000_0000);
    send_request(dmc_pkg::OP_READ, 16'hFFFF, 32'h0);
    send_request(dmc_pkg::OP_READ, 16'h0200, 32'h0);
    send_request(dmc_pkg::OP_READ, 16'h0000, 32'h0);
    send_request(dmc_pkg::OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(dmc_pkg::OP_WRITE, 16'h5555, 32'hAAAA_AAAA);
    send_request(dmc_pkg::OP_WRITE, 16'hAAAA, 32'h5555_5555);
    send_request(dmc_pkg::OP_FLUSH, 16'h0, 32'h0);
    send_request(dmc_pkg::OP_READ, 16'h5555, 32'h0);
    send_request(dmc_pkg::OP_READ, 16'hAAAA, 32'h0);
    send_request(dmc_pkg::OP_FLUSH, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(dmc_pkg::OP_FLUSH, 16'h0, 32'h0);
    for (int i = 0; i < 8; i++) hot_addr[i] = 16'($urandom_range(0, 65535));
    for (int i = 0; i < 450; i++) begin
      if ($urandom_range(0, 99) < 60)
        a = hot_addr[$urandom_range(0, 7)] ^ 16'($urandom_range(0, 31));
      else a = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 99) < 5) hot_addr[$urandom_range(0, 7)] = a;
      send_request(pick_op(), a, $urandom());
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
